// File: hdl/wlcr_pkg.sv
// Shared constants, types and helper functions of the wear-levelled counter ring.
package wlcr_pkg;

  // Number of slots in the ring.
  localparam int SLOTS = 8;

  // Slot address, 0-based, and slot numbers 1..SLOTS (0 means no current slot).
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NUM_W = ($clog2(SLOTS + 1) > 4) ? $clog2(SLOTS + 1) : 4;

  // Field widths.
  localparam int HALF_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int INDEX_W = 4;

  // The high word that marks the slot before it as current.
  localparam logic [HALF_W-1:0] MARKER = 16'hFFFF;

  // Contents of slot one after reset; every other slot holds zero.
  localparam logic [HALF_W-1:0] FIRST_SLOT_INIT = 16'h00FF;

  localparam logic [IDX_W-1:0] LAST_ADDR  = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] FIRST_ADDR = '0;

  // Operation codes.
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_CAPT,
    ST_WR_DATA,
    ST_WR_MARK,
    ST_RESP
  } state_t;

  // Word that a slot holds before it is first written.
  function automatic logic [HALF_W-1:0] reset_word(input logic [IDX_W-1:0] addr);
    reset_word = (addr == FIRST_ADDR) ? FIRST_SLOT_INIT : '0;
  endfunction

  // Slot address after the given one, wrapping round at the end of the ring.
  function automatic logic [IDX_W-1:0] next_addr(input logic [IDX_W-1:0] addr);
    next_addr = (addr == LAST_ADDR) ? FIRST_ADDR : addr + IDX_W'(1);
  endfunction

endpackage

// File: hdl/wlcr_if.sv
// Handshake interfaces for the command channel and the result channel.
interface wlcr_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [wlcr_pkg::TOTAL_W-1:0]     energy_value;

  modport source (output valid, output opcode, output energy_value, input ready);
  modport sink   (input valid, input opcode, input energy_value, output ready);
endinterface

interface wlcr_out_if;
  logic                             valid;
  logic                             ready;
  logic [wlcr_pkg::TOTAL_W-1:0]     energy_total;
  logic [wlcr_pkg::INDEX_W-1:0]     slot_index;

  modport source (output valid, output energy_total, output slot_index, input ready);
  modport sink   (input valid, input energy_total, input slot_index, output ready);
endinterface

// File: hdl/wlcr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module wlcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// File: hdl/wear_leveled_counter_ring.sv
// Top level of the wear-levelled counter ring: marker scan sequencer and slot storage.
//
//   channel | dir | handshake         | beat payload
//   --------+-----+-------------------+-----------------------------------
//   in_ch   | in  | valid / ready     | opcode, energy_value
//   out_ch  | out | valid / ready     | energy_total, slot_index
//
// A beat runs from acceptance through a marker scan to a result in the output register.
// The marker scan issues one high word a cycle through the single read port of the
// high-word RAM and tests it in the cycle after; it ends at the last slot or early at the
// first marker. Then a read loads the current slot, if any, or a write stores the new total
// and the marker, and the result is handed to the output register. A new beat is taken only
// when the sequencer is back in idle, so a beat is never taken before the last one is done.
// Reset restores the reset contents at once through per-slot valid bits; no clearing pass
// is needed. A stalled result holds the sequencer in its last state until the beat is taken.
module wear_leveled_counter_ring (
  input  logic          clk,
  input  logic          rst_n,
  wlcr_in_if.sink       in_ch,
  wlcr_out_if.source    out_ch
);

  wlcr_pkg::state_t                 state_r, state_nxt;

  logic                             op_r, op_nxt;
  logic [wlcr_pkg::TOTAL_W-1:0]     value_r, value_nxt;

  logic [wlcr_pkg::IDX_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic [wlcr_pkg::IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                             chk_vld_r, chk_vld_nxt;

  logic [wlcr_pkg::IDX_W-1:0]       cur_addr_r, cur_addr_nxt;
  logic [wlcr_pkg::IDX_W-1:0]       tgt_addr_r, tgt_addr_nxt;

  logic [wlcr_pkg::TOTAL_W-1:0]     res_total_r, res_total_nxt;
  logic [wlcr_pkg::INDEX_W-1:0]     res_index_r, res_index_nxt;

  logic [wlcr_pkg::SLOTS-1:0]       hi_vld_r, hi_vld_nxt;
  logic [wlcr_pkg::SLOTS-1:0]       lo_vld_r, lo_vld_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [wlcr_pkg::TOTAL_W-1:0]     out_total_r, out_total_nxt;
  logic [wlcr_pkg::INDEX_W-1:0]     out_index_r, out_index_nxt;

  // RAM ports.
  logic                             hi_we, lo_we;
  logic [wlcr_pkg::IDX_W-1:0]       hi_waddr, hi_raddr;
  logic [wlcr_pkg::HALF_W-1:0]      hi_wdata, lo_wdata;
  logic [wlcr_pkg::HALF_W-1:0]      hi_rdata, lo_rdata;

  // Effective words, with never-written slots reading their reset contents.
  logic [wlcr_pkg::HALF_W-1:0]      chk_word;
  logic [wlcr_pkg::HALF_W-1:0]      cur_hi_word, cur_lo_word;
  logic                             hit;
  logic [wlcr_pkg::NUM_W-1:0]       cur_num;
  logic [wlcr_pkg::NUM_W-1:0]       tgt_num;
  logic                             out_free;

  // Slot storage: high words and low words in separate RAMs.
  wlcr_ram #(
    .WIDTH (wlcr_pkg::HALF_W),
    .DEPTH (wlcr_pkg::SLOTS)
  ) u_hi_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (hi_waddr),
    .wdata (hi_wdata),
    .raddr (hi_raddr),
    .rdata (hi_rdata)
  );

  wlcr_ram #(
    .WIDTH (wlcr_pkg::HALF_W),
    .DEPTH (wlcr_pkg::SLOTS)
  ) u_lo_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (tgt_addr_r),
    .wdata (lo_wdata),
    .raddr (cur_addr_r),
    .rdata (lo_rdata)
  );

  // Word under test in the scan, and the current slot's words after a load.
  assign chk_word    = hi_vld_r[chk_idx_r]  ? hi_rdata : wlcr_pkg::reset_word(chk_idx_r);
  assign cur_hi_word = hi_vld_r[cur_addr_r] ? hi_rdata : wlcr_pkg::reset_word(cur_addr_r);
  assign cur_lo_word = lo_vld_r[cur_addr_r] ? lo_rdata : wlcr_pkg::reset_word(cur_addr_r);
  assign hit         = chk_vld_r && (chk_word == wlcr_pkg::MARKER);

  // A marker in the first slot makes the last slot current; elsewhere the one before.
  assign cur_num = !hit ? '0 :
                   (chk_idx_r == wlcr_pkg::FIRST_ADDR) ? wlcr_pkg::NUM_W'(wlcr_pkg::SLOTS) :
                   wlcr_pkg::NUM_W'(chk_idx_r);
  // The slot written is the marked slot itself, or the first slot when none is marked.
  assign tgt_num = hit ? wlcr_pkg::NUM_W'(chk_idx_r) + wlcr_pkg::NUM_W'(1)
                       : wlcr_pkg::NUM_W'(1);

  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == wlcr_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.energy_total = out_total_r;
  assign out_ch.slot_index   = out_index_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wlcr_pkg::ST_IDLE;
      chk_vld_r   <= 1'b0;
      hi_vld_r    <= '0;
      lo_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      hi_vld_r    <= hi_vld_nxt;
      lo_vld_r    <= lo_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    value_r     <= value_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    cur_addr_r  <= cur_addr_nxt;
    tgt_addr_r  <= tgt_addr_nxt;
    res_total_r <= res_total_nxt;
    res_index_r <= res_index_nxt;
    out_total_r <= out_total_nxt;
    out_index_r <= out_index_nxt;
  end

  // Sequencer: next state, RAM control and result formation.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    value_nxt     = value_r;
    scan_addr_nxt = scan_addr_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = 1'b0;
    cur_addr_nxt  = cur_addr_r;
    tgt_addr_nxt  = tgt_addr_r;
    res_total_nxt = res_total_r;
    res_index_nxt = res_index_r;
    hi_vld_nxt    = hi_vld_r;
    lo_vld_nxt    = lo_vld_r;
    out_total_nxt = out_total_r;
    out_index_nxt = out_index_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    hi_we    = 1'b0;
    lo_we    = 1'b0;
    hi_waddr = tgt_addr_r;
    hi_wdata = value_r[wlcr_pkg::TOTAL_W-1:wlcr_pkg::HALF_W];
    lo_wdata = value_r[wlcr_pkg::HALF_W-1:0];
    hi_raddr = cur_addr_r;

    unique case (state_r)
      wlcr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt        = in_ch.opcode;
          value_nxt     = in_ch.energy_value;
          scan_addr_nxt = wlcr_pkg::FIRST_ADDR;
          state_nxt     = wlcr_pkg::ST_SCAN;
        end
      end

      // One high word is issued a cycle; its data is tested in the cycle after.
      wlcr_pkg::ST_SCAN: begin
        hi_raddr    = scan_addr_r;
        chk_idx_nxt = scan_addr_r;
        chk_vld_nxt = 1'b1;
        if (scan_addr_r != wlcr_pkg::LAST_ADDR) begin
          scan_addr_nxt = scan_addr_r + wlcr_pkg::IDX_W'(1);
        end
        if (hit || (chk_vld_r && (chk_idx_r == wlcr_pkg::LAST_ADDR))) begin
          chk_vld_nxt  = 1'b0;
          cur_addr_nxt = (chk_idx_r == wlcr_pkg::FIRST_ADDR) ? wlcr_pkg::LAST_ADDR
                                                             : chk_idx_r - wlcr_pkg::IDX_W'(1);
          tgt_addr_nxt = hit ? chk_idx_r : wlcr_pkg::FIRST_ADDR;
          if (op_r == wlcr_pkg::OP_WRITE) begin
            res_total_nxt = value_r;
            res_index_nxt = tgt_num[wlcr_pkg::INDEX_W-1:0];
            state_nxt     = wlcr_pkg::ST_WR_DATA;
          end else begin
            res_total_nxt = '0;
            res_index_nxt = cur_num[wlcr_pkg::INDEX_W-1:0];
            state_nxt     = hit ? wlcr_pkg::ST_LOAD : wlcr_pkg::ST_RESP;
          end
        end
      end

      // Read both words of the current slot.
      wlcr_pkg::ST_LOAD: begin
        hi_raddr  = cur_addr_r;
        state_nxt = wlcr_pkg::ST_CAPT;
      end

      wlcr_pkg::ST_CAPT: begin
        res_total_nxt = {cur_hi_word, cur_lo_word};
        state_nxt     = wlcr_pkg::ST_RESP;
      end

      // Store the new total in the target slot.
      wlcr_pkg::ST_WR_DATA: begin
        hi_we                  = 1'b1;
        lo_we                  = 1'b1;
        hi_vld_nxt[tgt_addr_r] = 1'b1;
        lo_vld_nxt[tgt_addr_r] = 1'b1;
        state_nxt              = wlcr_pkg::ST_WR_MARK;
      end

      // Place the marker in the slot after the target.
      wlcr_pkg::ST_WR_MARK: begin
        hi_we    = 1'b1;
        hi_waddr = wlcr_pkg::next_addr(tgt_addr_r);
        hi_wdata = wlcr_pkg::MARKER;
        hi_vld_nxt[wlcr_pkg::next_addr(tgt_addr_r)] = 1'b1;
        state_nxt = wlcr_pkg::ST_RESP;
      end

      // Hand the result to the output register once it is free.
      wlcr_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = res_total_r;
          out_index_nxt = res_index_r;
          state_nxt     = wlcr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wlcr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: bench/wear_leveled_counter_ring_test.sv
// Self-checking testbench of the counter ring with bursty commands and a stalling sink.
module wear_leveled_counter_ring_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_BEATS   = 1000;

  // Receiver behaviours, each held for a random stretch of cycles.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  typedef struct {
    wlcr_pkg::opcode_t            op;
    logic [wlcr_pkg::TOTAL_W-1:0] value;
  } command_t;

  typedef struct {
    logic [wlcr_pkg::TOTAL_W-1:0] energy_total;
    logic [wlcr_pkg::INDEX_W-1:0] slot_index;
  } ring_result_t;

  logic clk;
  logic rst_n;

  wlcr_in_if  in_ch ();
  wlcr_out_if out_ch ();

  wear_leveled_counter_ring dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Our own copy of the slot contents, 0-based by slot address.
  logic [wlcr_pkg::HALF_W-1:0] ring_hi [wlcr_pkg::SLOTS];
  logic [wlcr_pkg::HALF_W-1:0] ring_lo [wlcr_pkg::SLOTS];

  command_t     pending_cmds [$];
  ring_result_t awaited_results [$];
  command_t     held_cmd;

  int       error_count = 0;
  int       reads_seen = 0;
  int       writes_seen = 0;
  int       empty_reads = 0;
  int       wrap_writes = 0;
  int       marker_like_writes = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       idle_cycles = 0;
  int       rx_phase_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one accepted command to the slot copy and queue the result it must give.
  task automatic predict_command(input command_t cmd);
    int           cur;
    int           target;
    int           mark;
    ring_result_t res;
    cur = 0;
    if (ring_hi[0] == wlcr_pkg::MARKER) begin
      cur = wlcr_pkg::SLOTS;
    end else begin
      for (int k = 2; k <= wlcr_pkg::SLOTS; k++) begin
        if (cur == 0 && ring_hi[k-1] == wlcr_pkg::MARKER) cur = k - 1;
      end
    end
    if (cmd.op == wlcr_pkg::OP_READ) begin
      reads_seen++;
      if (cur == 0) begin
        empty_reads++;
        res.energy_total = '0;
      end else begin
        res.energy_total = {ring_hi[cur-1], ring_lo[cur-1]};
      end
      res.slot_index = wlcr_pkg::INDEX_W'(cur);
    end else begin
      writes_seen++;
      target = (cur % wlcr_pkg::SLOTS) + 1;
      mark   = (target % wlcr_pkg::SLOTS) + 1;
      if (target == wlcr_pkg::SLOTS) wrap_writes++;
      if (cmd.value[wlcr_pkg::TOTAL_W-1:wlcr_pkg::HALF_W] == wlcr_pkg::MARKER) begin
        marker_like_writes++;
      end
      ring_hi[target-1] = cmd.value[wlcr_pkg::TOTAL_W-1:wlcr_pkg::HALF_W];
      ring_lo[target-1] = cmd.value[wlcr_pkg::HALF_W-1:0];
      ring_hi[mark-1]   = wlcr_pkg::MARKER;
      res.energy_total  = cmd.value;
      res.slot_index    = wlcr_pkg::INDEX_W'(target);
    end
    awaited_results.push_back(res);
  endtask

  task automatic queue_cmd(input wlcr_pkg::opcode_t op,
                           input logic [wlcr_pkg::TOTAL_W-1:0] value);
    command_t cmd;
    cmd.op    = op;
    cmd.value = value;
    pending_cmds.push_back(cmd);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    command_t cmd;
    int       sel;
    int       bit_pos;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = wlcr_pkg::OP_READ;
    in_ch.energy_value = '0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;
    held_cmd.op        = wlcr_pkg::OP_READ;
    held_cmd.value     = '0;
    for (int k = 0; k < wlcr_pkg::SLOTS; k++) begin
      ring_hi[k] = (k == 0) ? wlcr_pkg::FIRST_SLOT_INIT : '0;
      ring_lo[k] = (k == 0) ? wlcr_pkg::FIRST_SLOT_INIT : '0;
    end

    // Directed part: the empty ring, stored words that look like markers,
    // several markers at once, the wrap into slot one and the field extremes.
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'hFFFF_FFFF);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h1234_5678);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'hA5A5_5A5A);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h5A5A_A5A5);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h0000_FFFF);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'hFFFF_0000);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h8000_0001);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h7FFF_FFFE);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'h0001_0000);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'hCAFE_F00D);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);
    queue_cmd(wlcr_pkg::OP_READ,  32'hFFFF_FFFF);
    queue_cmd(wlcr_pkg::OP_WRITE, 32'hFFFF_FFFF);
    queue_cmd(wlcr_pkg::OP_READ,  32'h0000_0000);

    // Random part: reads and writes mixed, with a bias towards values whose
    // high half imitates a marker and towards the extremes.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      cmd.op  = ($urandom_range(0, 99) < 55) ? wlcr_pkg::OP_WRITE : wlcr_pkg::OP_READ;
      sel     = $urandom_range(0, 9);
      bit_pos = $urandom_range(0, wlcr_pkg::TOTAL_W - 1);
      case (sel)
        0: begin
          cmd.value = '0;
        end
        1: begin
          cmd.value = '1;
        end
        2: begin
          cmd.value = {wlcr_pkg::MARKER, 16'($urandom)};
        end
        3: begin
          cmd.value = wlcr_pkg::TOTAL_W'(1) << bit_pos;
        end
        4: begin
          cmd.value = ~(wlcr_pkg::TOTAL_W'(1) << bit_pos);
        end
        default: begin
          cmd.value = $urandom;
        end
      endcase
      pending_cmds.push_back(cmd);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the active edge so that the driver's updates have settled.
    while (pending_cmds.size() != 0 || in_ch.valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d reads (%0d with no current slot) and %0d writes,",
             reads_seen, empty_reads, writes_seen);
    $display("including %0d writes into the last slot and %0d with a marker-like high word.",
             wrap_writes, marker_like_writes);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Command driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_command(held_cmd);
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the beat until the ring takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        held_cmd = pending_cmds.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= held_cmd.op;
        in_ch.energy_value <= held_cmd.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and sink: compares each beat and stalls on its own pattern.
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got total %h slot %0d",
                   $time, out_ch.energy_total, out_ch.slot_index);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.energy_total !== want.energy_total) begin
            error_count++;
            $display("%0t: energy_total mismatch: expected %h, got %h",
                     $time, want.energy_total, out_ch.energy_total);
          end
          if (out_ch.slot_index !== want.slot_index) begin
            error_count++;
            $display("%0t: slot_index mismatch: expected %0d, got %0d",
                     $time, want.slot_index, out_ch.slot_index);
          end
        end
      end
      rx_tick++;
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(20, 200);
      end else begin
        rx_phase_left--;
      end
      case (rx_mode)
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        RX_PERIODIC: begin
          out_ch.ready <= (rx_tick % 7) >= 3;
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 15) == 0);
        end
      endcase
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
               $time, idle_cycles, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
hdl/wlcr_pkg.sv
hdl/wlcr_if.sv
hdl/wlcr_ram.sv
hdl/wear_leveled_counter_ring.sv
bench/wear_leveled_counter_ring_test.sv
